// File: rtl/core/lta_pkg.sv
// ----------------------------------------------------------------------------
// lta_pkg
// Shared types and constants for the LATM to ADTS reframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lta_pkg;

  // Framing phase codes
  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_PAY  = 2'd1;
  localparam logic [1:0] PH_DROP = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SRATE = 2'd0;
  localparam logic [1:0] CFG_CHAN  = 2'd1;
  localparam logic [1:0] CFG_MPEG2 = 2'd2;

  localparam int unsigned CFG_DATA_W = 4;

  // Header constants
  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [7:0]  SYNC_MPEG4    = 8'hF1;
  localparam logic [7:0]  SYNC_MPEG2    = 8'hF9;
  localparam logic [7:0]  PROFILE_LC    = 8'h40;
  localparam logic [10:0] FULLNESS      = 11'h7FF;
  localparam logic [2:0]  HDR_LAST      = 3'd6;
  localparam logic [14:0] HDR_LEN       = 15'd7;
  localparam logic [14:0] ADTS_MAX      = 15'd8191;
  localparam logic [13:0] SUM_MAX       = 14'h3FFF;
  localparam logic [7:0]  LEN_MORE      = 8'hFF;

  // Live configuration
  typedef struct packed {
    logic [3:0] sample_rate_index;
    logic [2:0] channel_config;
    logic       mpeg2_id;
  } cfg_t;

  // One queued result group: a payload byte or a whole 7-byte header
  typedef struct packed {
    logic        is_hdr;
    logic [7:0]  data;
    logic        last;
    logic [12:0] total;
  } desc_t;

endpackage

`default_nettype wire

// File: rtl/core/lta_in_if.sv
// ----------------------------------------------------------------------------
// lta_in_if
// Input byte channel: LATM payload bytes with packet framing.
// ----------------------------------------------------------------------------
`default_nettype none

interface lta_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_of_packet;
  logic [15:0] packet_size;

  modport source (output valid, output data_byte, output first_of_packet,
                  output packet_size, input ready);
  modport sink (input valid, input data_byte, input first_of_packet,
                input packet_size, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lta_out_if.sv
// ----------------------------------------------------------------------------
// lta_out_if
// Output byte channel: ADTS stream bytes with end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lta_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/latm_to_adts_reframer_core.sv
// ----------------------------------------------------------------------------
// latm_to_adts_reframer_core
// Parses LATM length fields and rebuilds each frame as ADTS header + payload.
// ----------------------------------------------------------------------------
// Each result group is registered in the result queue before it is offered.
// Throughput: 1 input byte per cycle; a header is sent as seven output bytes,
//   and input stalls once the two-entry result queue behind it is full.
// Reset (rst, synchronous): framing state cleared, queue empty, config
//   registers return to sample rate index 3, channel config 2, mpeg2_id 0.
`default_nettype none

module latm_to_adts_reframer_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  lta_in_if.sink                              in_ch,
  lta_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [lta_pkg::CFG_DATA_W-1:0] cfg_data
);

  lta_pkg::cfg_t cfg;

  logic [1:0]  phase;
  logic [13:0] length_sum;
  logic [12:0] payload_left;
  logic [15:0] packet_left;

  logic [1:0]  phase_next;
  logic [13:0] length_sum_next;
  logic [12:0] payload_left_next;
  logic [15:0] packet_left_next;

  logic           accept;
  logic           full;
  logic           push;
  lta_pkg::desc_t push_desc;

  logic [1:0]  ph_eff;
  logic [13:0] sum_eff;
  logic [12:0] pay_eff;
  logic [15:0] pl_eff;
  logic [15:0] pl_dec;
  logic [12:0] pay_dec;
  logic [14:0] sum_add;
  logic [13:0] sum_sat;
  logic [14:0] total;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_rate_index <= 4'd3;
      cfg.channel_config    <= 3'd2;
      cfg.mpeg2_id          <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lta_pkg::CFG_SRATE: cfg.sample_rate_index <= cfg_data[3:0];
        lta_pkg::CFG_CHAN:  cfg.channel_config    <= cfg_data[2:0];
        lta_pkg::CFG_MPEG2: cfg.mpeg2_id          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Per-byte framing step
  always_comb begin
    ph_eff  = in_ch.first_of_packet ? lta_pkg::PH_LEN : phase;
    sum_eff = in_ch.first_of_packet ? 14'd0 : length_sum;
    pay_eff = in_ch.first_of_packet ? 13'd0 : payload_left;
    pl_eff  = in_ch.first_of_packet ? in_ch.packet_size : packet_left;
    pl_dec  = pl_eff - 16'd1;
    pay_dec = pay_eff - 13'd1;
    sum_add = {1'b0, sum_eff} + {7'd0, in_ch.data_byte};
    sum_sat = sum_add[14] ? lta_pkg::SUM_MAX : sum_add[13:0];
    total   = {1'b0, sum_sat} + lta_pkg::HDR_LEN;

    phase_next        = ph_eff;
    length_sum_next   = sum_eff;
    payload_left_next = pay_eff;
    packet_left_next  = pl_eff;
    push              = 1'b0;
    push_desc.is_hdr  = 1'b0;
    push_desc.data    = in_ch.data_byte;
    push_desc.last    = 1'b0;
    push_desc.total   = total[12:0];

    if (pl_eff != 16'd0) begin
      packet_left_next = pl_dec;
      case (ph_eff)
        lta_pkg::PH_PAY: begin
          payload_left_next = pay_dec;
          push              = 1'b1;
          if (pay_dec == 13'd0) begin
            phase_next      = lta_pkg::PH_LEN;
            length_sum_next = 14'd0;
            push_desc.last  = 1'b1;
          end
        end
        lta_pkg::PH_LEN: begin
          length_sum_next = sum_sat;
          if (in_ch.data_byte == lta_pkg::LEN_MORE) begin
            if (pl_dec == 16'd0) phase_next = lta_pkg::PH_DROP;
          end else if (total > lta_pkg::ADTS_MAX || {2'b00, sum_sat} > pl_dec) begin
            phase_next = lta_pkg::PH_DROP;
          end else begin
            push             = 1'b1;
            push_desc.is_hdr = 1'b1;
            length_sum_next  = 14'd0;
            if (sum_sat == 14'd0) begin
              push_desc.last = 1'b1;
              phase_next     = lta_pkg::PH_LEN;
            end else begin
              payload_left_next = sum_sat[12:0];
              phase_next        = lta_pkg::PH_PAY;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lta_pkg::PH_LEN;
      length_sum   <= 14'd0;
      payload_left <= 13'd0;
      packet_left  <= 16'd0;
    end else if (accept) begin
      phase        <= phase_next;
      length_sum   <= length_sum_next;
      payload_left <= payload_left_next;
      packet_left  <= packet_left_next;
    end
  end

  // Result queue and header serializer
  lta_emit_queue u_emit (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && push),
    .push_desc (push_desc),
    .cfg       (cfg),
    .full      (full),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: rtl/core/lta_emit_queue.sv
// ----------------------------------------------------------------------------
// lta_emit_queue
// Two-entry queue of result groups; serializes headers one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lta_emit_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lta_pkg::desc_t push_desc,
  input  wire lta_pkg::cfg_t  cfg,
  output logic               full,
  lta_out_if.source          out_ch
);

  logic           head_valid;
  lta_pkg::desc_t head;
  logic [2:0]     idx;
  logic           tail_valid;
  lta_pkg::desc_t tail;

  logic head_last;
  logic step;
  logic pop;

  assign head_last = head.is_hdr ? (idx == lta_pkg::HDR_LAST) : 1'b1;
  assign step      = head_valid && out_ch.ready;
  assign pop       = step && head_last;
  assign full      = tail_valid;

  // Header byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (step) begin
      idx <= head_last ? 3'd0 : idx + 3'd1;
    end
  end

  // Queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (!head_valid || pop) begin
      if (tail_valid) begin
        head_valid <= 1'b1;
        tail_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      tail_valid <= 1'b1;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      if (tail_valid) begin
        head <= tail;
        if (push) tail <= push_desc;
      end else begin
        head <= push_desc;
      end
    end else if (push) begin
      tail <= push_desc;
    end
  end

  // Output byte select
  always_comb begin
    out_ch.valid     = head_valid;
    out_ch.frame_end = head.last && head_last;
    out_ch.out_byte  = head.data;
    if (head.is_hdr) begin
      case (idx)
        3'd0: out_ch.out_byte = lta_pkg::SYNC_BYTE;
        3'd1: out_ch.out_byte = cfg.mpeg2_id ? lta_pkg::SYNC_MPEG2 : lta_pkg::SYNC_MPEG4;
        3'd2: out_ch.out_byte = lta_pkg::PROFILE_LC | {2'b00, cfg.sample_rate_index, 1'b0,
                                                       cfg.channel_config[2]};
        3'd3: out_ch.out_byte = {cfg.channel_config[1:0], 4'b0000, head.total[12:11]};
        3'd4: out_ch.out_byte = head.total[10:3];
        3'd5: out_ch.out_byte = {head.total[2:0], lta_pkg::FULLNESS[10:6]};
        3'd6: out_ch.out_byte = {lta_pkg::FULLNESS[5:0], 2'b00};
        default: out_ch.out_byte = 8'h00;
      endcase
    end
  end

endmodule

`default_nettype wire
